/* src/fqdv_pkg.sv */
// shared types and constants for the ordered handle queue with delete by value
`default_nettype none

package fqdv_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 7;
  localparam int STEP_N = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_DEL = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic valid;
    logic force_hit;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* src/fqdv_in_if.sv */
// request channel: action and handle
`default_nettype none

interface fqdv_in_if;
  import fqdv_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [DATA_W-1:0] item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink   (input valid, input action, input item_value, output ready);
endinterface

`default_nettype wire

/* src/fqdv_out_if.sv */
// result channel: status, removed handle and occupancy
`default_nettype none

interface fqdv_out_if;
  import fqdv_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [DATA_W-1:0] out_value;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output out_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input out_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* src/fqdv_cell.sv */
// one queue slot: holds a handle, compares it with the key and shifts toward the front
`default_nettype none

module fqdv_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  fqdv_pkg::cell_ctl_t        ctl,
  input  wire  [fqdv_pkg::DATA_W-1:0]      key,
  input  wire  [fqdv_pkg::DATA_W-1:0]      load_value,
  input  wire  [fqdv_pkg::DATA_W-1:0]      next_value,
  output logic [fqdv_pkg::DATA_W-1:0]      value,
  output logic                             match
);
  import fqdv_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = load_value;
    end else if (ctl.shift) begin
      data_nxt = next_value;
    end
    match_nxt = match_r;
    if (ctl.capture) begin
      match_nxt = ctl.valid && (ctl.force_hit || (data_r == key));
    end
  end

  // handle storage needs no reset, slots above the count are never read
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign value = data_r;
  assign match = match_r;

endmodule

`default_nettype wire

/* src/fifo_queue_with_delete_by_value.sv */
// top level: ordered handle queue built as a row of shifting slots
//
//   channel   dir   fields                              handshake
//   in_chan   in    action, item_value                  valid/ready
//   out_chan  out   status, out_value, occupancy        valid/ready
//
// each transaction has an accept and an apply cycle: in the accept cycle every slot
// compares its handle with the incoming key; in the apply cycle a prefix OR over the
// match bits picks the slots that shift forward, so one request is in flight at a time
// in_chan.ready is high outside the apply cycle, even while a result waits
// a stalled result holds the apply cycle until out_chan.ready frees the register
// reset clears the count, the state and the output valid; slot contents stay as they are
`default_nettype none

module fifo_queue_with_delete_by_value (
  input  wire        clk,
  input  wire        rst_n,
  fqdv_in_if.sink    in_chan,
  fqdv_out_if.source out_chan
);
  import fqdv_pkg::*;

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request held for the apply cycle
  action_t           op_r;
  logic [DATA_W-1:0] key_r;

  // result register
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  // slot row
  logic [DATA_W-1:0] cell_val  [DEPTH];
  logic [DATA_W-1:0] cell_next [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [DEPTH-1:0]  shift_mask;
  cell_ctl_t         cell_ctl  [DEPTH];

  logic    in_accept;
  logic    do_apply;
  logic    enq_go;
  logic    shift_go;
  action_t in_op;

  assign in_accept = in_chan.valid && in_chan.ready;
  assign in_op     = action_t'(in_chan.action);
  assign in_chan.ready = (state_r == S_IDLE);
  // apply only when the result register is free or being emptied
  assign do_apply = (state_r == S_APPLY) && (!out_valid_r || out_chan.ready);

  // prefix OR: a slot shifts if it or any slot in front of it matched
  always_comb begin
    shift_mask = cell_match;
    for (int s = 0; s < STEP_N; s++) begin
      shift_mask = shift_mask | (shift_mask << (1 << s));
    end
  end

  // decide the outcome of the held request
  always_comb begin
    status_nxt = ST_OK;
    value_nxt  = '0;
    enq_go     = 1'b0;
    shift_go   = 1'b0;
    count_nxt  = count_r;
    case (op_r)
      ACT_ENQ: begin
        if (key_r == '0) begin
          status_nxt = ST_ZERO;
        end else if (count_r >= CNT_W'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          enq_go    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DEQ: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          value_nxt = cell_val[0];
          shift_go  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_DEL: begin
        if (key_r == '0) begin
          status_nxt = ST_ZERO;
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (|cell_match) begin
          shift_go  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      default: begin
        // unused action code: no change
        status_nxt = ST_OK;
      end
    endcase
    occ_nxt = OCC_W'(count_nxt);
  end

  // slot controls; dequeue forces a hit on the front slot
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i < DEPTH - 1) begin : g_mid
        assign cell_next[i] = cell_val[i+1];
      end else begin : g_last
        assign cell_next[i] = '0;
      end

      always_comb begin
        cell_ctl[i].capture   = in_accept;
        cell_ctl[i].valid     = (CNT_W'(i) < count_r);
        cell_ctl[i].force_hit = (i == 0) && (in_op == ACT_DEQ);
        cell_ctl[i].shift     = do_apply && shift_go && shift_mask[i];
        cell_ctl[i].load      = do_apply && enq_go && (count_r == CNT_W'(i));
      end

      fqdv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl[i]),
        .key        (in_chan.item_value),
        .load_value (key_r),
        .next_value (cell_next[i]),
        .value      (cell_val[i]),
        .match      (cell_match[i])
      );
    end
  endgenerate

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_accept) begin
        state_nxt = S_APPLY;
      end
      S_APPLY: if (do_apply) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_apply) begin
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_op;
      key_r <= in_chan.item_value;
    end
    if (do_apply) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      occ_r    <= occ_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.out_value = value_r;
  assign out_chan.occupancy = occ_r;

endmodule

`default_nettype wire
